/* src/dzmvc_pkg.sv */
// Shared types, codes and constants for the dual zone motor voltage control block.
package dzmvc_pkg;

  localparam int DUTY_FRAC_BITS_DEF = 12;

  localparam int MUL_AW = 24;
  localparam int MUL_BW = 15;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_DW = 19;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [14:0] TRACK_MV_RST   = 15'd14000;
  localparam logic [14:0] START_MV_RST   = 15'd0;
  localparam logic [7:0]  PROP_GAIN_RST  = 8'd2;
  localparam logic [7:0]  INT_GAIN_RST   = 8'd5;
  localparam logic [7:0]  KICK_RST       = 8'd0;
  localparam logic [7:0]  DITHER_RST     = 8'd0;
  localparam logic [15:0] MAX_RPM_RST    = 16'd3000;

  localparam logic [11:0] KICK_FULL_MV   = 12'd4000;
  localparam logic [18:0] DITHER_DIV     = 19'd382500;
  localparam logic [18:0] STEP_DIV       = 19'd255;
  localparam logic [18:0] TORQUE_DIV     = 19'd510;
  localparam logic [18:0] TEN            = 19'd10;
  localparam logic [18:0] DITHER_PERIOD  = 19'd40;
  localparam logic [18:0] DITHER_HALF    = 19'd20;
  localparam logic [31:0] KICK_MS        = 32'd100;
  localparam logic [15:0] RIPPLE_LIMIT   = 16'd100;
  localparam logic [7:0]  TORQUE_STEPS   = 8'd20;
  localparam logic [7:0]  DITHER_STEPS   = 8'd15;
  localparam int          KICK_LOW_MV    = 100;
  localparam int          SLEW_UP_MV     = 400;
  localparam int          SLEW_DN_MV     = 20;
  localparam int          DEADBAND       = 5;
  localparam int          INT_LIMIT      = 1000;

  typedef enum logic [2:0] {
    REG_TRACK_MV,
    REG_START_MV,
    REG_PROP_GAIN,
    REG_INT_GAIN,
    REG_KICK,
    REG_DITHER,
    REG_MAX_RPM
  } reg_idx_t;

  typedef enum logic [1:0] {
    ZONE_STOP,
    ZONE_TORQUE,
    ZONE_VELOCITY
  } zone_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_APPL,
    S_KMUL,
    S_KDIV,
    S_TMUL,
    S_TDIV,
    S_PDIV,
    S_RMUL,
    S_RDIV,
    S_IMUL1,
    S_IMUL2,
    S_IDIV,
    S_SLEW,
    S_DDIV,
    S_AMUL,
    S_ADIV,
    S_MOD,
    S_SAT,
    S_OMUL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

/* src/dual_zone_motor_voltage_control_top.sv */
// Top level: tick sequencer, control state and shared serial arithmetic.
//
// channel | handshake             | beat
// in      | in_valid / in_stall   | speed_step forward now_ms measured_rpm ripple_decihz winding_mohm
// out     | out_valid / out_stall | duty_q12 applied_mv zone kick_on
// cfg     | cfg_valid / cfg_ready | cfg_index cfg_data
//
// A running tick is worked through the shared bit-serial multiplier and divider in turn,
// with NW = max(32, DUTY_FRAC_BITS + 18) as the divider width.
// A stop tick (speed_step 0) goes from idle straight to the output state.
// Synchronous reset restores register defaults and clears the control state.
// in_stall is high while a tick is in progress; a finished beat waits in the output
// register, so the next beat is taken while it is still stalled.
module dual_zone_motor_voltage_control_top #(
  parameter int DUTY_FRAC_BITS = dzmvc_pkg::DUTY_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            speed_step,
  input  logic                                  forward,
  input  logic [31:0]                           now_ms,
  input  logic [15:0]                           measured_rpm,
  input  logic [15:0]                           ripple_decihz,
  input  logic [15:0]                           winding_mohm,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [13:0]                    duty_q12,
  output logic [14:0]                           applied_mv,
  output logic [1:0]                            zone,
  output logic                                  kick_on,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dzmvc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dzmvc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int F   = DUTY_FRAC_BITS;
  localparam int DHW = F + 2;
  localparam int DWW = F + 3;
  localparam int NW  = (F + 18 > 32) ? F + 18 : 32;
  localparam int AW  = dzmvc_pkg::MUL_AW;
  localparam int BW  = dzmvc_pkg::MUL_BW;
  localparam int PW  = dzmvc_pkg::MUL_PW;
  localparam int DW  = dzmvc_pkg::DIV_DW;
  localparam int FULL = 1 << F;

  // configuration
  logic [14:0] track_voltage_mv;
  logic [14:0] start_voltage_mv;
  logic [7:0]  prop_gain_code;
  logic [7:0]  integral_gain_code;
  logic [7:0]  kick_strength;
  logic [7:0]  dither_strength;
  logic [15:0] max_rpm;

  // control state
  dzmvc_pkg::state_t state, state_next;
  logic launch;
  logic signed [DHW-1:0] duty_held;
  logic [14:0]           last_control;
  logic signed [23:0]    error_integral;
  logic                  kick_active;
  logic [31:0]           kick_start_ms;

  // tick work registers
  logic [7:0]            step_r;
  logic                  fwd_r;
  logic [31:0]           now_r;
  logic [15:0]           rpm_r;
  logic [15:0]           ripple_r;
  logic [15:0]           rmohm_r;
  logic                  kick_use;
  logic [11:0]           kick_mv;
  logic signed [31:0]    vt;
  logic signed [31:0]    work;
  logic signed [17:0]    err;
  logic signed [DWW-1:0] duty_w;
  logic [F:0]            amp;
  logic                  phase_add;
  logic [14:0]           applied_r;
  dzmvc_pkg::zone_t      zone_r;

  // arithmetic units
  logic                    mul_start, mul_use;
  logic [AW-1:0]           mul_a;
  logic [BW-1:0]           mul_b;
  logic [PW-1:0]           mul_prod;
  dzmvc_pkg::unit_status_t mul_status;
  logic                    div_start, div_use;
  logic [NW-1:0]           div_num;
  logic [DW-1:0]           div_den;
  logic [NW-1:0]           div_q;
  logic [DW-1:0]           div_r;
  dzmvc_pkg::unit_status_t div_status;

  // combinational helpers
  logic [DHW-1:0]        duty_mag;
  logic                  torque;
  logic                  dith;
  logic [3:0]            dstep;
  logic [9:0]            c39;
  logic [11:0]           kp10;
  logic [23:0]           int_mag;
  logic [17:0]           err_mag;
  logic signed [17:0]    err_new;
  logic signed [24:0]    int_sum;
  logic signed [23:0]    int_upd;
  logic signed [31:0]    prod_s;
  logic signed [31:0]    q_s;
  logic signed [31:0]    last_s;
  logic signed [31:0]    track_s;
  logic signed [31:0]    vc;
  logic signed [DWW-1:0] d_sum;
  logic signed [DWW-1:0] d_sat;
  logic signed [DWW-1:0] d_fin;
  logic [31:0]           kstart;
  logic                  kick_trig;
  logic                  out_free;

  assign in_stall  = (state != dzmvc_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  assign duty_mag = duty_held[DHW-1] ? DHW'(-duty_held) : DHW'(duty_held);
  assign torque   = (ripple_r <= dzmvc_pkg::RIPPLE_LIMIT) && (step_r < dzmvc_pkg::TORQUE_STEPS);
  assign dith     = (step_r < dzmvc_pkg::DITHER_STEPS) && (dither_strength != '0);
  assign dstep    = 4'(dzmvc_pkg::DITHER_STEPS - step_r);
  assign c39      = 10'({dstep, 5'b0}) + 10'({dstep, 2'b0}) + 10'({dstep, 1'b0}) + 10'(dstep);
  assign kp10     = 12'({prop_gain_code, 3'b0}) + 12'({prop_gain_code, 1'b0});
  assign int_mag  = error_integral[23] ? 24'(-error_integral) : 24'(error_integral);
  assign err_mag  = err[17] ? 18'(-err) : 18'(err);
  assign err_new  = $signed({2'b0, div_q[15:0]}) - $signed({2'b0, rpm_r});
  assign int_sum  = 25'(error_integral) + 25'(err_new);
  assign prod_s   = $signed(mul_prod[31:0]);
  assign q_s      = (work < 0) ? -$signed(32'(div_q)) : $signed(32'(div_q));
  assign last_s   = $signed({17'b0, last_control});
  assign track_s  = $signed({17'b0, track_voltage_mv});
  assign kick_trig = !kick_active && (mul_prod < (PW'(dzmvc_pkg::KICK_LOW_MV) << F));
  assign kstart   = kick_trig ? now_r : kick_start_ms;

  always_comb begin
    if (int_sum > 25'(dzmvc_pkg::INT_LIMIT)) begin
      int_upd = 24'(dzmvc_pkg::INT_LIMIT);
    end else if (int_sum < -25'(dzmvc_pkg::INT_LIMIT)) begin
      int_upd = -24'(dzmvc_pkg::INT_LIMIT);
    end else begin
      int_upd = int_sum[23:0];
    end
  end

  always_comb begin
    vc = vt;
    if (vt > last_s + 32'sd400) begin
      vc = last_s + 32'(dzmvc_pkg::SLEW_UP_MV);
    end
    if (vt < last_s - 32'sd20) begin
      vc = last_s - 32'(dzmvc_pkg::SLEW_DN_MV);
    end
    if (vc > track_s) begin
      vc = track_s;
    end
    if (vc < 0) begin
      vc = '0;
    end
  end

  always_comb begin
    d_sum = phase_add ? duty_w + $signed(DWW'(amp)) : duty_w - $signed(DWW'(amp));
    if (d_sum > DWW'(FULL)) begin
      d_sat = DWW'(FULL);
    end else if (d_sum < -DWW'(FULL)) begin
      d_sat = -DWW'(FULL);
    end else begin
      d_sat = d_sum;
    end
    d_fin = fwd_r ? d_sat : -d_sat;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= dzmvc_pkg::S_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= (state_next != state);
    end
  end

  always_comb begin
    state_next = state;
    mul_use    = 1'b0;
    div_use    = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_num    = '0;
    div_den    = '0;
    unique case (state)
      dzmvc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (speed_step == '0) ? dzmvc_pkg::S_OUT : dzmvc_pkg::S_APPL;
        end
      end
      dzmvc_pkg::S_APPL: begin
        mul_use = 1'b1;
        mul_a   = AW'(duty_mag);
        mul_b   = track_voltage_mv;
        if (mul_status.done) state_next = dzmvc_pkg::S_KMUL;
      end
      dzmvc_pkg::S_KMUL: begin
        mul_use = 1'b1;
        mul_a   = AW'(dzmvc_pkg::KICK_FULL_MV);
        mul_b   = BW'(kick_strength);
        if (mul_status.done) state_next = dzmvc_pkg::S_KDIV;
      end
      dzmvc_pkg::S_KDIV: begin
        div_use = 1'b1;
        div_num = NW'(mul_prod);
        div_den = dzmvc_pkg::STEP_DIV;
        if (div_status.done) state_next = torque ? dzmvc_pkg::S_TMUL : dzmvc_pkg::S_RMUL;
      end
      dzmvc_pkg::S_TMUL: begin
        mul_use = 1'b1;
        mul_a   = AW'(rmohm_r);
        mul_b   = BW'(step_r);
        if (mul_status.done) state_next = dzmvc_pkg::S_TDIV;
      end
      dzmvc_pkg::S_TDIV: begin
        div_use = 1'b1;
        div_num = NW'(mul_prod);
        div_den = dzmvc_pkg::TORQUE_DIV;
        if (div_status.done) begin
          state_next = (integral_gain_code != '0) ? dzmvc_pkg::S_PDIV : dzmvc_pkg::S_SLEW;
        end
      end
      dzmvc_pkg::S_PDIV: begin
        div_use = 1'b1;
        div_num = (NW'(vt) << 3) + (NW'(vt) << 1);
        div_den = DW'(integral_gain_code);
        if (div_status.done) state_next = dzmvc_pkg::S_SLEW;
      end
      dzmvc_pkg::S_RMUL: begin
        mul_use = 1'b1;
        mul_a   = AW'(max_rpm);
        mul_b   = BW'(step_r);
        if (mul_status.done) state_next = dzmvc_pkg::S_RDIV;
      end
      dzmvc_pkg::S_RDIV: begin
        div_use = 1'b1;
        div_num = NW'(mul_prod);
        div_den = dzmvc_pkg::STEP_DIV;
        if (div_status.done) state_next = dzmvc_pkg::S_IMUL1;
      end
      dzmvc_pkg::S_IMUL1: begin
        mul_use = 1'b1;
        mul_a   = AW'(err_mag);
        mul_b   = BW'(kp10);
        if (mul_status.done) state_next = dzmvc_pkg::S_IMUL2;
      end
      dzmvc_pkg::S_IMUL2: begin
        mul_use = 1'b1;
        mul_a   = int_mag;
        mul_b   = BW'(integral_gain_code);
        if (mul_status.done) state_next = dzmvc_pkg::S_IDIV;
      end
      dzmvc_pkg::S_IDIV: begin
        div_use = 1'b1;
        div_num = (work < 0) ? NW'(-work) + NW'(9) : NW'(work);
        div_den = dzmvc_pkg::TEN;
        if (div_status.done) state_next = dzmvc_pkg::S_SLEW;
      end
      dzmvc_pkg::S_SLEW: begin
        if (track_voltage_mv != '0) begin
          state_next = dzmvc_pkg::S_DDIV;
        end else begin
          state_next = dith ? dzmvc_pkg::S_AMUL : dzmvc_pkg::S_SAT;
        end
      end
      dzmvc_pkg::S_DDIV: begin
        div_use = 1'b1;
        div_num = (NW'(last_control) << F) + NW'(track_voltage_mv[14:1]);
        div_den = DW'(track_voltage_mv);
        if (div_status.done) state_next = dith ? dzmvc_pkg::S_AMUL : dzmvc_pkg::S_SAT;
      end
      dzmvc_pkg::S_AMUL: begin
        mul_use = 1'b1;
        mul_a   = AW'(dither_strength);
        mul_b   = BW'(c39);
        if (mul_status.done) state_next = dzmvc_pkg::S_ADIV;
      end
      dzmvc_pkg::S_ADIV: begin
        div_use = 1'b1;
        div_num = NW'(mul_prod) << F;
        div_den = dzmvc_pkg::DITHER_DIV;
        if (div_status.done) state_next = dzmvc_pkg::S_MOD;
      end
      dzmvc_pkg::S_MOD: begin
        div_use = 1'b1;
        div_num = NW'(now_r);
        div_den = dzmvc_pkg::DITHER_PERIOD;
        if (div_status.done) state_next = dzmvc_pkg::S_SAT;
      end
      dzmvc_pkg::S_SAT: begin
        state_next = dzmvc_pkg::S_OMUL;
      end
      dzmvc_pkg::S_OMUL: begin
        mul_use = 1'b1;
        mul_a   = AW'(duty_mag);
        mul_b   = track_voltage_mv;
        if (mul_status.done) state_next = dzmvc_pkg::S_OUT;
      end
      dzmvc_pkg::S_OUT: begin
        if (out_free) state_next = dzmvc_pkg::S_IDLE;
      end
      default: state_next = dzmvc_pkg::S_IDLE;
    endcase
  end

  assign mul_start = launch && mul_use;
  assign div_start = launch && div_use;

  dzmvc_mul #(
    .AW(AW),
    .BW(BW)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .prod   (mul_prod),
    .status (mul_status)
  );

  dzmvc_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .quo    (div_q),
    .rem    (div_r),
    .status (div_status)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      track_voltage_mv   <= dzmvc_pkg::TRACK_MV_RST;
      start_voltage_mv   <= dzmvc_pkg::START_MV_RST;
      prop_gain_code     <= dzmvc_pkg::PROP_GAIN_RST;
      integral_gain_code <= dzmvc_pkg::INT_GAIN_RST;
      kick_strength      <= dzmvc_pkg::KICK_RST;
      dither_strength    <= dzmvc_pkg::DITHER_RST;
      max_rpm            <= dzmvc_pkg::MAX_RPM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dzmvc_pkg::REG_TRACK_MV:  track_voltage_mv   <= cfg_data[14:0];
        dzmvc_pkg::REG_START_MV:  start_voltage_mv   <= cfg_data[14:0];
        dzmvc_pkg::REG_PROP_GAIN: prop_gain_code     <= cfg_data[7:0];
        dzmvc_pkg::REG_INT_GAIN:  integral_gain_code <= cfg_data[7:0];
        dzmvc_pkg::REG_KICK:      kick_strength      <= cfg_data[7:0];
        dzmvc_pkg::REG_DITHER:    dither_strength    <= cfg_data[7:0];
        dzmvc_pkg::REG_MAX_RPM:   max_rpm            <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state kept across ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_held      <= '0;
      last_control   <= '0;
      error_integral <= '0;
      kick_active    <= 1'b0;
      kick_start_ms  <= '0;
    end else begin
      unique case (state)
        dzmvc_pkg::S_IDLE: begin
          if (in_valid && speed_step == '0) begin
            duty_held      <= '0;
            last_control   <= '0;
            error_integral <= '0;
            kick_active    <= 1'b0;
          end
        end
        dzmvc_pkg::S_APPL: begin
          if (mul_status.done) begin
            kick_start_ms <= kstart;
            kick_active   <= (kick_active || kick_trig) && (now_r - kstart < dzmvc_pkg::KICK_MS);
          end
        end
        dzmvc_pkg::S_PDIV: begin
          if (div_status.done) error_integral <= div_q[23:0];
        end
        dzmvc_pkg::S_RDIV: begin
          if (div_status.done && (err_new > 18'sd5 || err_new < -18'sd5)) begin
            error_integral <= int_upd;
          end
        end
        dzmvc_pkg::S_SLEW: last_control <= vc[14:0];
        dzmvc_pkg::S_SAT:  duty_held    <= DHW'(d_fin);
        default: ;
      endcase
    end
  end

  // per-tick working values
  always_ff @(posedge clk) begin
    unique case (state)
      dzmvc_pkg::S_IDLE: begin
        if (in_valid) begin
          step_r    <= speed_step;
          fwd_r     <= forward;
          now_r     <= now_ms;
          rpm_r     <= measured_rpm;
          ripple_r  <= ripple_decihz;
          rmohm_r   <= winding_mohm;
          applied_r <= '0;
          zone_r    <= dzmvc_pkg::ZONE_STOP;
        end
      end
      dzmvc_pkg::S_APPL: begin
        if (mul_status.done) begin
          kick_use <= (kick_active || kick_trig) && (now_r - kstart < dzmvc_pkg::KICK_MS);
        end
      end
      dzmvc_pkg::S_KDIV: begin
        if (div_status.done) begin
          kick_mv <= kick_use ? div_q[11:0] : '0;
          zone_r  <= torque ? dzmvc_pkg::ZONE_TORQUE : dzmvc_pkg::ZONE_VELOCITY;
        end
      end
      dzmvc_pkg::S_TDIV: begin
        if (div_status.done) begin
          vt <= 32'(div_q[15:0]) + 32'(start_voltage_mv) + 32'(kick_mv);
        end
      end
      dzmvc_pkg::S_RDIV: begin
        if (div_status.done) err <= err_new;
      end
      dzmvc_pkg::S_IMUL1: begin
        if (mul_status.done) work <= err[17] ? -prod_s : prod_s;
      end
      dzmvc_pkg::S_IMUL2: begin
        if (mul_status.done) work <= work + (error_integral[23] ? -prod_s : prod_s);
      end
      dzmvc_pkg::S_IDIV: begin
        if (div_status.done) begin
          vt <= q_s + 32'(start_voltage_mv) + 32'(kick_mv);
        end
      end
      dzmvc_pkg::S_SLEW: begin
        duty_w    <= '0;
        amp       <= '0;
        phase_add <= 1'b1;
      end
      dzmvc_pkg::S_DDIV: begin
        if (div_status.done) duty_w <= DWW'(div_q[F:0]);
      end
      dzmvc_pkg::S_ADIV: begin
        if (div_status.done) amp <= div_q[F:0];
      end
      dzmvc_pkg::S_MOD: begin
        if (div_status.done) phase_add <= div_r < dzmvc_pkg::DITHER_HALF;
      end
      dzmvc_pkg::S_OMUL: begin
        if (mul_status.done) applied_r <= 15'(mul_prod >> F);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == dzmvc_pkg::S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dzmvc_pkg::S_OUT && out_free) begin
      duty_q12   <= 14'(duty_held);
      applied_mv <= applied_r;
      zone       <= zone_r;
      kick_on    <= kick_active;
    end
  end

`ifndef SYNTHESIS
  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == dzmvc_pkg::S_OUT && out_free) |=> out_valid)
    else $error("finished tick not presented");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    (state == dzmvc_pkg::S_IDLE) |-> (!mul_status.busy && !div_status.busy))
    else $error("arithmetic unit busy while idle");

  a_stop_beat: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && zone == dzmvc_pkg::ZONE_STOP) |->
      (duty_q12 == '0 && applied_mv == '0 && !kick_on))
    else $error("stop beat carries drive");

  a_slew_clamp: assert property (@(posedge clk) disable iff (rst)
    (state == dzmvc_pkg::S_SLEW && !(cfg_valid && cfg_ready)) |=>
      (last_control <= track_voltage_mv))
    else $error("control voltage above track voltage");
`endif

endmodule

/* src/dzmvc_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module dzmvc_mul #(
  parameter int AW = dzmvc_pkg::MUL_AW,
  parameter int BW = dzmvc_pkg::MUL_BW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [AW-1:0]          a,
  input  logic [BW-1:0]          b,
  output logic [AW+BW-1:0]       prod,
  output dzmvc_pkg::unit_status_t status
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0]    mcand;
  logic [AW+BW-1:0] acc;
  logic [CW-1:0]    count;
  logic             busy;
  logic             done;
  logic [AW:0]      sum;

  assign sum = {1'b0, acc[AW+BW-1:BW]} + (acc[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        count <= CW'(BW);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mcand <= a;
      acc   <= {AW'(0), b};
    end else if (busy) begin
      acc <= {sum, acc[BW-1:1]};
    end
  end

  assign prod        = acc;
  assign status.busy = busy;
  assign status.done = done;

endmodule

/* src/dzmvc_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module dzmvc_div #(
  parameter int NW = 32,
  parameter int DW = dzmvc_pkg::DIV_DW
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NW-1:0]           num,
  input  logic [DW-1:0]           den,
  output logic [NW-1:0]           quo,
  output logic [DW-1:0]           rem,
  output dzmvc_pkg::unit_status_t status
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] den_r;
  logic [CW-1:0] count;
  logic          busy;
  logic          done;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem, quo[NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        count <= CW'(NW);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      den_r <= den;
      rem   <= '0;
      quo   <= num;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule
